FILE: rtl/sxe_pkg.sv
`default_nettype none

package sxe_pkg;

  // fixed field widths
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned ERR_W       = 3;
  localparam int unsigned DEPTH_W     = 5;

  // default stack size
  localparam int unsigned STACK_DEPTH = 16;

  // instruction codes
  typedef enum logic [CMD_W-1:0] {
    CMD_NOP    = 3'd0,
    CMD_PUSH   = 3'd1,
    CMD_POP    = 3'd2,
    CMD_UNARY  = 3'd3,
    CMD_BINARY = 3'd4,
    CMD_PRINT  = 3'd5
  } cmd_e;

  // operator codes, shared by unary and binary instructions and the alu
  typedef enum logic [OP_W-1:0] {
    OP_PLUS  = 3'd0,
    OP_MINUS = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_REM   = 3'd4
  } op_e;

  // error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 3'd0,
    ERR_UNDERFLOW = 3'd1,
    ERR_OVERFLOW  = 3'd2,
    ERR_DIVZERO   = 3'd3,
    ERR_BADOP     = 3'd4
  } err_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD_B,
    ST_LOAD_A,
    ST_START,
    ST_BUSY,
    ST_SHOW,
    ST_FINISH,
    ST_PRINT
  } sxe_state_e;

  // alu states
  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_DIV,
    ALU_FIX,
    ALU_DONE
  } alu_state_e;

  // request from the sequencer to the alu
  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

endpackage

`default_nettype wire

FILE: rtl/sxe_if.sv
`default_nettype none

// instruction channel
interface sxe_cmd_if
  import sxe_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [DATA_W-1:0] push_value;
  logic [OP_W-1:0]   operator_code;

  modport source (output valid, command, push_value, operator_code, input ready);
  modport sink   (input valid, command, push_value, operator_code, output ready);
endinterface

// result channel
interface sxe_res_if
  import sxe_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    result_value;
  logic                 printed;
  logic [ERR_W-1:0]     error_code;
  logic [DEPTH_W-1:0]   stack_depth;

  modport source (output valid, result_value, printed, error_code, stack_depth, input ready);
  modport sink   (input valid, result_value, printed, error_code, stack_depth, output ready);
endinterface

`default_nettype wire

FILE: rtl/sxe_alu.sv
`default_nettype none

module sxe_alu
  import sxe_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  alu_req_t           req_i,
  input  wire [DATA_W-1:0]   a_i,
  input  wire [DATA_W-1:0]   b_i,
  output logic               done_o,
  output logic [DATA_W-1:0]  result_o
);

  localparam int unsigned CntW = $clog2(DATA_W);

  alu_state_e        state_q, state_d;
  logic [CntW-1:0]   cnt_q;
  logic [DATA_W-1:0] res_q;
  logic [DATA_W-1:0] rem_q, quo_q, dvs_q;
  logic              neg_q, want_rem_q;

  logic              is_div_op;
  logic              last_step;
  logic [DATA_W:0]   rem_sh, diff;
  logic              fits;
  logic [DATA_W-1:0] rem_d, quo_d;
  logic [DATA_W-1:0] abs_a, abs_b;

  assign is_div_op = (req_i.op == OP_DIV) || (req_i.op == OP_REM);
  assign last_step = (cnt_q == CntW'(DATA_W - 1));

  // operand magnitudes
  assign abs_a = a_i[DATA_W-1] ? ('0 - a_i) : a_i;
  assign abs_b = b_i[DATA_W-1] ? ('0 - b_i) : b_i;

  // one restoring division step
  assign rem_sh = {rem_q, quo_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign fits   = ~diff[DATA_W];
  assign rem_d  = fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
  assign quo_d  = {quo_q[DATA_W-2:0], fits};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          state_d = is_div_op ? ALU_DIV : ALU_DONE;
        end
      end
      ALU_DIV: begin
        if (last_step) begin
          state_d = ALU_FIX;
        end
      end
      ALU_FIX:  state_d = ALU_DONE;
      ALU_DONE: state_d = ALU_IDLE;
      default:  state_d = ALU_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o   = 1'b0;
    result_o = res_q;
    case (state_q)
      ALU_DONE: done_o = 1'b1;
      default:  done_o = 1'b0;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ALU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            OP_PLUS:  res_q <= a_i + b_i;
            OP_MINUS: res_q <= a_i - b_i;
            OP_MUL:   res_q <= a_i * b_i;
            default:  res_q <= a_i + b_i;
          endcase
          dvs_q      <= abs_b;
          quo_q      <= abs_a;
          rem_q      <= '0;
          cnt_q      <= '0;
          want_rem_q <= (req_i.op == OP_REM);
          neg_q      <= (req_i.op == OP_REM) ? a_i[DATA_W-1]
                                             : (a_i[DATA_W-1] ^ b_i[DATA_W-1]);
        end
      end
      ALU_DIV: begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q + CntW'(1);
      end
      ALU_FIX: begin
        // restore signs, quotient toward zero, remainder follows dividend
        if (want_rem_q) begin
          res_q <= neg_q ? ('0 - rem_q) : rem_q;
        end else begin
          res_q <= neg_q ? ('0 - quo_q) : quo_q;
        end
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/stack_expression_evaluator_top.sv
`default_nettype none
// channel   dir  payload                                            words
// cmd_i     in   command, push_value, operator_code                 one instruction
// res_o     out  result_value, printed, error_code, stack_depth     one per instruction
//
// one instruction at a time: ready returns once the result word of the last one is loaded;
// print goes straight from the check to the result; negate and binary operators first read
// their operands, and divide by zero is caught before the alu starts
// (the alu takes one quotient bit per cycle for divide or remainder)
// reset clears the stack pointer and the control state; stack entries are not cleared
// a stalled result sits in the output register while the next instruction is taken

module stack_expression_evaluator_top
  import sxe_pkg::*;
#(
  parameter int unsigned StackDepth = STACK_DEPTH
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  sxe_cmd_if.sink   cmd_i,
  sxe_res_if.source res_o
);

  localparam int unsigned SpW   = $clog2(StackDepth + 1);
  localparam int unsigned AddrW = $clog2(StackDepth);

  sxe_state_e        state_q, state_d;
  cmd_e              cmd_q;
  op_e               op_q;
  err_e              err_q, err_d;
  logic [DATA_W-1:0] pv_q, a_q, b_q, rd_data_q;
  logic [SpW-1:0]    sp_q, sp_d, sp_m1, sp_m2;

  logic              cmd_fire, out_free;
  logic              empty, full, few, bad_un, bad_bin, go_print, go_operand, div_zero;

  logic              mem_we, rd_en;
  logic [AddrW-1:0]  waddr, raddr;
  logic [DATA_W-1:0] wdata;
  logic              load_a, load_b, zero_a, out_load;
  logic [DATA_W-1:0] out_value_d;
  logic              out_printed_d;

  alu_req_t          alu_req;
  logic              alu_done;
  logic [DATA_W-1:0] alu_result;

  logic              out_valid_q, out_printed_q;
  logic [DATA_W-1:0] out_value_q;
  err_e              out_err_q;
  logic [DEPTH_W-1:0] out_depth_q;

  logic [DATA_W-1:0] stack_mem [StackDepth];

  // handshake
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || res_o.ready;

  // stack status and checks
  assign sp_m1      = sp_q - SpW'(1);
  assign sp_m2      = sp_q - SpW'(2);
  assign empty      = (sp_q == '0);
  assign full       = (sp_q >= SpW'(StackDepth));
  assign few        = (sp_q < SpW'(2));
  assign bad_un     = (op_q != OP_PLUS) && (op_q != OP_MINUS);
  assign bad_bin    = (op_q != OP_PLUS) && (op_q != OP_MINUS) && (op_q != OP_MUL) &&
                      (op_q != OP_DIV) && (op_q != OP_REM);
  assign go_print   = (cmd_q == CMD_PRINT) && !empty;
  assign go_operand = ((cmd_q == CMD_UNARY) && !empty && (op_q == OP_MINUS)) ||
                      ((cmd_q == CMD_BINARY) && !few && !bad_bin);
  assign div_zero   = (cmd_q == CMD_BINARY) && ((op_q == OP_DIV) || (op_q == OP_REM)) &&
                      (b_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (go_print) begin
          state_d = ST_PRINT;
        end else if (go_operand) begin
          state_d = ST_LOAD_B;
        end else begin
          state_d = ST_SHOW;
        end
      end
      ST_LOAD_B: state_d = (cmd_q == CMD_BINARY) ? ST_LOAD_A : ST_START;
      ST_LOAD_A: state_d = ST_START;
      ST_START:  state_d = div_zero ? ST_SHOW : ST_BUSY;
      ST_BUSY: begin
        if (alu_done) begin
          state_d = ST_SHOW;
        end
      end
      ST_SHOW:   state_d = ST_FINISH;
      ST_FINISH, ST_PRINT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mem_we        = 1'b0;
    waddr         = sp_q[AddrW-1:0];
    wdata         = pv_q;
    rd_en         = 1'b0;
    raddr         = sp_m1[AddrW-1:0];
    sp_d          = sp_q;
    err_d         = err_q;
    load_a        = 1'b0;
    load_b        = 1'b0;
    zero_a        = 1'b0;
    alu_req       = '{start: 1'b0, op: OP_PLUS};
    out_load      = 1'b0;
    out_value_d   = rd_data_q;
    out_printed_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          err_d = ERR_OK;
        end
      end
      ST_CHECK: begin
        case (cmd_q)
          CMD_PUSH: begin
            if (full) begin
              err_d = ERR_OVERFLOW;
            end else begin
              mem_we = 1'b1;
              sp_d   = sp_q + SpW'(1);
            end
          end
          CMD_POP: begin
            if (empty) begin
              err_d = ERR_UNDERFLOW;
            end else begin
              sp_d = sp_m1;
            end
          end
          CMD_UNARY: begin
            if (empty) begin
              err_d = ERR_UNDERFLOW;
            end else if (bad_un) begin
              err_d = ERR_BADOP;
            end else begin
              rd_en = (op_q == OP_MINUS);
            end
          end
          CMD_BINARY: begin
            if (few) begin
              err_d = ERR_UNDERFLOW;
            end else if (bad_bin) begin
              err_d = ERR_BADOP;
            end else begin
              rd_en = 1'b1;
            end
          end
          CMD_PRINT: begin
            if (empty) begin
              err_d = ERR_UNDERFLOW;
            end else begin
              rd_en = 1'b1;
              sp_d  = sp_m1;
            end
          end
          default: begin
            err_d = ERR_OK;
          end
        endcase
      end
      ST_LOAD_B: begin
        load_b = 1'b1;
        if (cmd_q == CMD_BINARY) begin
          rd_en = 1'b1;
          raddr = sp_m2[AddrW-1:0];
        end else begin
          zero_a = 1'b1;
        end
      end
      ST_LOAD_A: begin
        load_a = 1'b1;
      end
      ST_START: begin
        if (div_zero) begin
          err_d = ERR_DIVZERO;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = (cmd_q == CMD_BINARY) ? op_q : OP_MINUS;
        end
      end
      ST_BUSY: begin
        if (alu_done) begin
          mem_we = 1'b1;
          wdata  = alu_result;
          if (cmd_q == CMD_BINARY) begin
            waddr = sp_m2[AddrW-1:0];
            sp_d  = sp_m1;
          end else begin
            waddr = sp_m1[AddrW-1:0];
          end
        end
      end
      ST_SHOW: begin
        rd_en = 1'b1;
      end
      ST_FINISH: begin
        out_load    = out_free;
        out_value_d = empty ? '0 : rd_data_q;
      end
      ST_PRINT: begin
        out_load      = out_free;
        out_printed_d = 1'b1;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sp_q        <= '0;
      err_q       <= ERR_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      err_q   <= err_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // instruction, operand and result word registers
  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      cmd_q <= cmd_e'(cmd_i.command);
      op_q  <= op_e'(cmd_i.operator_code);
      pv_q  <= cmd_i.push_value;
    end
    if (load_b) begin
      b_q <= rd_data_q;
    end
    if (load_a) begin
      a_q <= rd_data_q;
    end else if (zero_a) begin
      a_q <= '0;
    end
    if (out_load) begin
      out_value_q   <= out_value_d;
      out_printed_q <= out_printed_d;
      out_err_q     <= err_q;
      out_depth_q   <= DEPTH_W'(sp_q);
    end
  end

  // value stack, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_q <= stack_mem[raddr];
    end
  end

  // shared arithmetic unit
  sxe_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (a_q),
    .b_i      (b_q),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  // result port
  assign res_o.valid        = out_valid_q;
  assign res_o.result_value = out_value_q;
  assign res_o.printed      = out_printed_q;
  assign res_o.error_code   = out_err_q;
  assign res_o.stack_depth  = out_depth_q;

endmodule

`default_nettype wire

FILE: sim/stack_expression_evaluator_top_tb.sv
`timescale 1ns / 100ps

module stack_expression_evaluator_top_tb;
  import sxe_pkg::*;

  localparam int unsigned StackDepth = STACK_DEPTH;
  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned EndDrain   = 60;
  localparam int unsigned RandWords  = 560;
  localparam int unsigned MaxReports = 10;

  localparam logic [DATA_W-1:0] MostNeg = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MostPos = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] MinusOne = 32'hffff_ffff;

  typedef struct packed {
    logic [DATA_W-1:0]  value;
    logic               printed;
    err_e               err;
    logic [DEPTH_W-1:0] depth;
  } eval_word_t;

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PERIODIC,
    SINK_THROTTLED
  } sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  sxe_cmd_if cmd_if ();
  sxe_res_if res_if ();

  stack_expression_evaluator_top #(
    .StackDepth(StackDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  // shadow stack of the evaluator
  logic [DATA_W-1:0] shadow_stack [StackDepth];
  int unsigned       shadow_count;

  // expected results in issue order
  eval_word_t pending_results [$];

  int unsigned instr_count;
  int unsigned checked_count;
  int unsigned mismatch_count;
  int unsigned err_seen [5];
  int unsigned burst_left;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned idle_cycles;

  always #5 clk_i = ~clk_i;

  // execute one instruction on the shadow stack
  function automatic eval_word_t evaluate_instruction(logic [CMD_W-1:0] cmd,
                                                      logic [DATA_W-1:0] pv,
                                                      logic [OP_W-1:0] op);
    eval_word_t        w;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] res;
    longint            sl;
    longint            sr;
    logic [63:0]       quot;
    w.value   = '0;
    w.printed = 1'b0;
    w.err     = ERR_OK;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_count >= StackDepth) begin
          w.err = ERR_OVERFLOW;
        end else begin
          shadow_stack[shadow_count] = pv;
          shadow_count++;
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) w.err = ERR_UNDERFLOW;
        else shadow_count--;
      end
      CMD_UNARY: begin
        if (shadow_count == 0) begin
          w.err = ERR_UNDERFLOW;
        end else if (op > OP_MINUS) begin
          w.err = ERR_BADOP;
        end else if (op == OP_MINUS) begin
          shadow_stack[shadow_count-1] = '0 - shadow_stack[shadow_count-1];
        end
      end
      CMD_BINARY: begin
        if (shadow_count < 2) begin
          w.err = ERR_UNDERFLOW;
        end else if (op > OP_REM) begin
          w.err = ERR_BADOP;
        end else begin
          lhs = shadow_stack[shadow_count-2];
          rhs = shadow_stack[shadow_count-1];
          res = '0;
          case (op)
            OP_PLUS:  res = lhs + rhs;
            OP_MINUS: res = lhs - rhs;
            OP_MUL:   res = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                w.err = ERR_DIVZERO;
              end else begin
                // 64-bit math keeps most negative over minus one defined
                sl   = longint'(signed'(lhs));
                sr   = longint'(signed'(rhs));
                quot = (op == OP_DIV) ? sl / sr : sl % sr;
                res  = quot[DATA_W-1:0];
              end
            end
          endcase
          if (w.err == ERR_OK) begin
            shadow_stack[shadow_count-2] = res;
            shadow_count--;
          end
        end
      end
      CMD_PRINT: begin
        if (shadow_count == 0) begin
          w.err = ERR_UNDERFLOW;
        end else begin
          shadow_count--;
          w.value   = shadow_stack[shadow_count];
          w.printed = 1'b1;
        end
      end
      default: ;
    endcase
    if (!w.printed) w.value = (shadow_count == 0) ? '0 : shadow_stack[shadow_count-1];
    w.depth = shadow_count[DEPTH_W-1:0];
    return w;
  endfunction

  // offer one word, in bursts with random gaps between them
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] pv,
                           logic [OP_W-1:0] op);
    int unsigned gap;
    eval_word_t  w;
    if (burst_left == 0) begin
      gap        = $urandom_range(3, 0) == 0 ? $urandom_range(12, 1) : 0;
      burst_left = $urandom_range(10, 1);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.command       <= cmd;
    cmd_if.push_value    <= pv;
    cmd_if.operator_code <= op;
    do @(posedge clk_i); while (!cmd_if.ready);
    burst_left--;
    w = evaluate_instruction(cmd, pv, op);
    pending_results.push_back(w);
    err_seen[w.err]++;
    if (cmd != CMD_NOP && cmd <= CMD_PRINT) instr_count++;
  endtask

  task automatic push_value(logic [DATA_W-1:0] pv);
    send_word(CMD_PUSH, pv, OP_W'($urandom_range(7, 0)));
  endtask

  task automatic apply_op(logic [CMD_W-1:0] cmd, logic [OP_W-1:0] op);
    send_word(cmd, $urandom(), op);
  endtask

  // operand mix: small values make division by zero and exact quotients common
  function automatic logic [DATA_W-1:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 40) return $urandom_range(40, 0) - 20;
    if (sel < 55) begin
      case ($urandom_range(4, 0))
        0:       return MostNeg;
        1:       return MostPos;
        2:       return MinusOne;
        3:       return 32'd1;
        default: return '0;
      endcase
    end
    return $urandom();
  endfunction

  // well-formed postfix expression with random content
  task automatic send_expression();
    int unsigned operands;
    if (shadow_count > StackDepth - 4) begin
      repeat ($urandom_range(shadow_count, 1))
        apply_op(CMD_PRINT, OP_W'($urandom_range(7, 0)));
    end
    operands = $urandom_range(4, (shadow_count == 0) ? 2 : 1);
    repeat (operands) begin
      push_value(pick_operand());
      if ($urandom_range(3, 0) == 0)
        apply_op(CMD_UNARY, OP_W'($urandom_range(OP_MINUS, OP_PLUS)));
    end
    repeat (operands - 1) apply_op(CMD_BINARY, OP_W'($urandom_range(OP_REM, OP_PLUS)));
    if ($urandom_range(1, 0)) apply_op(CMD_PRINT, OP_W'($urandom_range(7, 0)));
  endtask

  // arbitrary word, including unknown commands and operators
  task automatic send_noise();
    send_word(CMD_W'($urandom_range(7, 0)), $urandom(), OP_W'($urandom_range(7, 0)));
  endtask

  task automatic test_empty_stack();
    apply_op(CMD_NOP, OP_PLUS);
    apply_op(CMD_POP, OP_PLUS);
    apply_op(CMD_UNARY, OP_MINUS);
    apply_op(CMD_PRINT, OP_PLUS);
    apply_op(CMD_BINARY, OP_PLUS);
    apply_op(3'd6, OP_PLUS);
    apply_op(3'd7, 3'd7);
  endtask

  task automatic test_unary_ops();
    push_value(MostNeg);
    apply_op(CMD_UNARY, OP_MINUS);
    apply_op(CMD_UNARY, OP_PLUS);
    apply_op(CMD_UNARY, OP_MUL);
    apply_op(CMD_UNARY, 3'd7);
    // underflow wins over a bad operator
    apply_op(CMD_BINARY, 3'd5);
    apply_op(CMD_POP, OP_PLUS);
  endtask

  task automatic test_binary_ops();
    push_value(MostPos);
    push_value(32'd1);
    apply_op(CMD_BINARY, OP_PLUS);
    push_value(MinusOne);
    apply_op(CMD_BINARY, OP_DIV);
    push_value(MinusOne);
    apply_op(CMD_BINARY, OP_REM);
    push_value(32'd3);
    apply_op(CMD_BINARY, OP_MINUS);
    push_value(MostPos);
    apply_op(CMD_BINARY, OP_MUL);
    push_value('0);
    // bad operator wins over a zero divisor
    apply_op(CMD_BINARY, 3'd6);
    apply_op(CMD_BINARY, OP_REM);
    apply_op(CMD_PRINT, OP_PLUS);
    push_value(-32'sd7);
    push_value(32'd2);
    apply_op(CMD_BINARY, OP_REM);
    push_value(32'd2);
    apply_op(CMD_BINARY, OP_DIV);
  endtask

  task automatic test_overflow();
    while (shadow_count < StackDepth) push_value($urandom());
    push_value($urandom());
    apply_op(CMD_PRINT, OP_PLUS);
  endtask

  // result side holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_requests++;
    repeat (4) send_expression();
  endtask

  task automatic test_random_mix();
    int unsigned sel;
    int unsigned start;
    start = instr_count;
    while (instr_count - start < RandWords) begin
      sel = $urandom_range(99, 0);
      if (sel < 4) begin
        while (shadow_count < StackDepth) push_value(pick_operand());
        push_value(pick_operand());
      end else if (sel < 75) begin
        send_expression();
      end else begin
        send_noise();
      end
    end
  endtask

  // result sink with its own stall pattern
  initial begin
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned phase;
    res_if.ready <= 1'b0;
    mode      = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LongHold;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(SINK_THROTTLED, SINK_OPEN));
        mode_left = $urandom_range(200, 20);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:     res_if.ready <= 1'b1;
          SINK_RANDOM:   res_if.ready <= ($urandom_range(1, 0) == 1);
          SINK_PERIODIC: res_if.ready <= (phase % 4) != 0;
          default:       res_if.ready <= ($urandom_range(7, 0) == 0);
        endcase
      end
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    eval_word_t w;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < MaxReports)
          $display("%0t: unexpected result word value=%h printed=%0d err=%0d depth=%0d",
                   $realtime, res_if.result_value, res_if.printed, res_if.error_code,
                   res_if.stack_depth);
        mismatch_count++;
      end else begin
        w = pending_results.pop_front();
        checked_count++;
        if (res_if.result_value !== w.value || res_if.printed !== w.printed ||
            res_if.error_code !== w.err || res_if.stack_depth !== w.depth) begin
          if (mismatch_count < MaxReports) begin
            $display("%0t: result %0d exp value=%h printed=%0d err=%0d depth=%0d",
                     $realtime, checked_count, w.value, w.printed, w.err, w.depth);
            $display("    got value=%h printed=%0d err=%0d depth=%0d",
                     res_if.result_value, res_if.printed, res_if.error_code,
                     res_if.stack_depth);
          end
          mismatch_count++;
        end
      end
    end
  end

  // stop if neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no handshake for %0d cycles", idle_cycles);
      $display("stack_expression_evaluator_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni               <= 1'b0;
    cmd_if.valid         <= 1'b0;
    cmd_if.command       <= CMD_NOP;
    cmd_if.push_value    <= '0;
    cmd_if.operator_code <= OP_PLUS;
    shadow_count   = 0;
    instr_count    = 0;
    checked_count  = 0;
    mismatch_count = 0;
    burst_left     = 0;
    hold_requests  = 0;
    hold_served    = 0;
    foreach (err_seen[i]) err_seen[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_stack();
    test_unary_ops();
    test_binary_ops();
    test_overflow();
    test_backpressure();
    test_random_mix();

    // drain outstanding results
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (EndDrain) @(posedge clk_i);

    $display("ran %0d instructions, checked %0d result words, %0d mismatches",
             instr_count, checked_count, mismatch_count);
    $display("error words: underflow %0d, overflow %0d, divide by zero %0d, bad operator %0d",
             err_seen[ERR_UNDERFLOW], err_seen[ERR_OVERFLOW], err_seen[ERR_DIVZERO],
             err_seen[ERR_BADOP]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("stack_expression_evaluator_top test passed");
    end else begin
      $display("stack_expression_evaluator_top test failed");
    end
    $finish;
  end

endmodule
